>>> rtl/core/multi_task_heartbeat_watchdog_macros.svh
// Assertion macros shared by the heartbeat watchdog RTL.
// No dependencies; included by the files that carry assertions.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define MTHW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mthw: assertion failed");
// Checks that a condition never occurs outside reset.
`define MTHW_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("mthw: forbidden condition seen");
`else
`define MTHW_ASSERT(lbl, clk, rstn, prop)
`define MTHW_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/core/mthw_pkg.sv
// Package for the heartbeat watchdog: command and result codes, field
// widths and the structs that travel along the cell chain. No dependencies.
package mthw_pkg;

    // Default number of table slots.
    localparam int SLOTS_DEF = 8;

    // Width of a slot number carried in the chain; covers up to 64 slots.
    localparam int SLOT_W = 6;

    localparam int OP_W     = 2;
    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int MISS_W   = 32;
    localparam int KIND_W   = 2;
    localparam int HEALTH_W = 2;
    localparam int OUT_SLOT_W = 3;

    // Command codes.
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
    localparam logic [OP_W-1:0] OP_REGISTER  = 2'd1;
    localparam logic [OP_W-1:0] OP_HEARTBEAT = 2'd2;
    localparam logic [OP_W-1:0] OP_CHECK     = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISS    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // Health levels, ordered by severity.
    localparam logic [HEALTH_W-1:0] HEALTH_OK      = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_LATE    = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_EXPIRED = 2'd2;

    // Token that walks the chain, one cell per cycle while the chain is not held, for heartbeat and check.
    typedef struct packed {
        logic                valid;
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   now;
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [HEALTH_W-1:0] worst;
    } t_tok;

    // Miss report raised by the cell that holds the token.
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   task_id;
        logic [MISS_W-1:0] total;
    } t_rep;

    // One result item as held in the output register.
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic                  accepted;
        logic [OUT_SLOT_W-1:0] slot;
        logic [ID_W-1:0]       missed_task;
        logic [MISS_W-1:0]     miss_total;
        logic [HEALTH_W-1:0]   health;
        logic                  last;
    } t_res;

endpackage

>>> rtl/core/mthw_cell.sv
// One slot of the watchdog table and its stage of the token chain.
// Depends on mthw_pkg.
module mthw_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_used,
    input  mthw_pkg::t_tok              i_tok,
    output mthw_pkg::t_tok              o_tok,
    output mthw_pkg::t_rep              o_rep,
    output logic                        o_here,
    input  logic                        i_wr,
    input  logic [mthw_pkg::ID_W-1:0]   i_wr_task,
    input  logic [mthw_pkg::TIME_W-1:0] i_wr_period,
    input  logic [mthw_pkg::TIME_W-1:0] i_wr_now
);
    import mthw_pkg::*;

    localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(IDX);

    t_tok              r_tok;
    logic [ID_W-1:0]   r_task;
    logic [TIME_W-1:0] r_period;
    logic [TIME_W-1:0] r_last_seen;
    logic [MISS_W-1:0] r_misses;

    logic              hit;
    logic              expired;
    logic              late;
    logic [TIME_W-1:0] elapsed;
    logic [MISS_W-1:0] n_misses;

    // Token register: takes the neighbor's token whenever the chain moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok.valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok.op    <= i_tok.op;
            r_tok.id    <= i_tok.id;
            r_tok.now   <= i_tok.now;
            r_tok.found <= i_tok.found;
            r_tok.slot  <= i_tok.slot;
            r_tok.worst <= i_tok.worst;
        end
    end

    // Compare this entry against the token it holds.
    always_comb begin
        elapsed  = r_tok.now - r_last_seen;
        n_misses = r_misses + MISS_W'(1);
        hit      = i_used && r_tok.valid && (r_tok.op == OP_HEARTBEAT)
                   && !r_tok.found && (r_task == r_tok.id);
        // Twice the period is formed by a shift within 64 bits: a top bit set never expires.
        expired  = i_used && r_tok.valid && (r_tok.op == OP_CHECK)
                   && !r_period[TIME_W-1]
                   && (elapsed > {r_period[TIME_W-2:0], 1'b0});
        late     = i_used && r_tok.valid && (r_tok.op == OP_CHECK)
                   && !expired && (elapsed > r_period);
    end

    // Token handed on to the next cell, with this entry's findings merged.
    always_comb begin
        o_tok = r_tok;
        if (hit) begin
            o_tok.found = 1'b1;
            o_tok.slot  = CELL_SLOT;
        end
        if (expired) begin
            o_tok.worst = HEALTH_EXPIRED;
        end else if (late && (r_tok.worst == HEALTH_OK)) begin
            o_tok.worst = HEALTH_LATE;
        end
    end

    // Miss report; all zero when idle so the top level can OR reports.
    always_comb begin
        o_rep = '0;
        if (expired) begin
            o_rep.valid   = 1'b1;
            o_rep.slot    = CELL_SLOT;
            o_rep.task_id = r_task;
            o_rep.total   = n_misses;
        end
    end

    assign o_here = r_tok.valid;

    // Entry storage: written by register, refreshed by heartbeat, counted by check.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_task      <= i_wr_task;
            r_period    <= i_wr_period;
            r_last_seen <= i_wr_now;
            r_misses    <= '0;
        end else if (i_adv) begin
            if (hit) begin
                r_last_seen <= r_tok.now;
            end
            if (expired) begin
                r_misses <= n_misses;
            end
        end
    end

endmodule

>>> rtl/core/multi_task_heartbeat_watchdog.sv
// Heartbeat watchdog for up to SLOTS tasks. Clear and register requests are
// answered from the output register in the cycle after acceptance. Heartbeat
// and check requests send a token down a chain of SLOTS cells, one cell per
// clock while no result waits on output stall; the token then waits in r_fin
// until its final result is loaded, and each miss report leaves as the token
// passes its cell. One request is worked on at a time; the next can be taken
// from the cycle after the last result enters the output register, once that register has room.
`include "multi_task_heartbeat_watchdog_macros.svh"

module multi_task_heartbeat_watchdog #(
    parameter int SLOTS = mthw_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mthw_pkg::OP_W-1:0]       i_opcode,
    input  logic [mthw_pkg::ID_W-1:0]       i_task_id,
    input  logic [mthw_pkg::TIME_W-1:0]     i_period_ns,
    input  logic [mthw_pkg::TIME_W-1:0]     i_now_ns,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mthw_pkg::KIND_W-1:0]     o_kind,
    output logic                            o_accepted,
    output logic [mthw_pkg::OUT_SLOT_W-1:0] o_slot_index,
    output logic [mthw_pkg::ID_W-1:0]       o_missed_task,
    output logic [mthw_pkg::MISS_W-1:0]     o_miss_total,
    output logic [mthw_pkg::HEALTH_W-1:0]   o_health,
    output logic                            o_last
);
    import mthw_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(SLOTS);

    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    t_tok             r_fin;
    logic             r_out_valid;
    t_res             r_out;
    t_res             n_out;
    logic             out_load;

    logic             out_free;
    logic             in_acc;
    logic             direct_go;
    logic             launch;
    logic             reg_ok;
    logic             adv;

    t_tok             tok_in  [SLOTS];
    t_tok             tok_out [SLOTS];
    t_rep             rep     [SLOTS];
    logic [SLOTS-1:0] here;
    logic [SLOTS-1:0] used;
    logic [SLOTS-1:0] wr;
    t_rep             rep_any;
    logic [$bits(t_rep)-1:0] rep_bits;

    // Handshake and request decode.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign launch     = in_acc && ((i_opcode == OP_HEARTBEAT) || (i_opcode == OP_CHECK));
    assign direct_go  = in_acc && !launch;
    assign reg_ok     = (r_count < FULL);

    // Merge the miss reports; only the cell holding the token can raise one.
    always_comb begin
        rep_bits = '0;
        for (int k = 0; k < SLOTS; k++) begin
            rep_bits = rep_bits | rep[k];
        end
        rep_any = t_rep'(rep_bits);
    end

    // The chain moves unless a result is waiting for room in the output register.
    assign adv = out_free || !(rep_any.valid || r_fin.valid);

    // Token launched into the first cell.
    always_comb begin
        tok_in[0]       = '0;
        tok_in[0].valid = launch;
        tok_in[0].op    = i_opcode;
        tok_in[0].id    = i_task_id;
        tok_in[0].now   = i_now_ns;
        tok_in[0].found = 1'b0;
        tok_in[0].slot  = '0;
        tok_in[0].worst = HEALTH_OK;
    end

    // The row of table cells.
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign tok_in[k] = tok_out[k-1];
        end
        assign used[k] = (CNT_W'(k) < r_count);
        assign wr[k]   = direct_go && (i_opcode == OP_REGISTER) && (r_count == CNT_W'(k));

        mthw_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (adv),
            .i_used      (used[k]),
            .i_tok       (tok_in[k]),
            .o_tok       (tok_out[k]),
            .o_rep       (rep[k]),
            .o_here      (here[k]),
            .i_wr        (wr[k]),
            .i_wr_task   (i_task_id),
            .i_wr_period (i_period_ns),
            .i_wr_now    (i_now_ns)
        );
    end

    // Table fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (direct_go) begin
            if (i_opcode == OP_CLEAR) begin
                r_count <= '0;
            end else if (reg_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Busy from launch until the final result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (launch) begin
            r_busy <= 1'b1;
        end else if (r_fin.valid && out_free) begin
            r_busy <= 1'b0;
        end
    end

    // Token leaving the last cell waits here until its final result goes out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid <= 1'b0;
        end else if (r_fin.valid) begin
            if (out_free) begin
                r_fin.valid <= 1'b0;
            end
        end else if (adv) begin
            r_fin.valid <= tok_out[SLOTS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_fin.valid && adv) begin
            r_fin.op    <= tok_out[SLOTS-1].op;
            r_fin.id    <= tok_out[SLOTS-1].id;
            r_fin.now   <= tok_out[SLOTS-1].now;
            r_fin.found <= tok_out[SLOTS-1].found;
            r_fin.slot  <= tok_out[SLOTS-1].slot;
            r_fin.worst <= tok_out[SLOTS-1].worst;
        end
    end

    // Select the next result: direct acknowledge, miss report or final result.
    always_comb begin
        n_out    = '0;
        out_load = 1'b0;
        if (direct_go) begin
            out_load       = 1'b1;
            n_out.kind     = KIND_ACK;
            n_out.last     = 1'b1;
            if (i_opcode == OP_CLEAR) begin
                n_out.accepted = 1'b1;
            end else if (reg_ok) begin
                n_out.accepted = 1'b1;
                n_out.slot     = OUT_SLOT_W'(r_count);
            end
        end else if (rep_any.valid && out_free) begin
            out_load          = 1'b1;
            n_out.kind        = KIND_MISS;
            n_out.slot        = rep_any.slot[OUT_SLOT_W-1:0];
            n_out.missed_task = rep_any.task_id;
            n_out.miss_total  = rep_any.total;
        end else if (r_fin.valid && out_free) begin
            out_load   = 1'b1;
            n_out.last = 1'b1;
            if (r_fin.op == OP_CHECK) begin
                n_out.kind   = KIND_SUMMARY;
                n_out.health = r_fin.worst;
            end else begin
                n_out.kind     = KIND_ACK;
                n_out.accepted = r_fin.found;
                if (r_fin.found) begin
                    n_out.slot = r_fin.slot[OUT_SLOT_W-1:0];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_accepted    = r_out.accepted;
    assign o_slot_index  = r_out.slot;
    assign o_missed_task = r_out.missed_task;
    assign o_miss_total  = r_out.miss_total;
    assign o_health      = r_out.health;
    assign o_last        = r_out.last;

    // At most one token is in flight, and only while the block is busy.
    `MTHW_ASSERT(a_one_token, i_clk, i_rst_n, $onehot0({here, r_fin.valid}))
    `MTHW_ASSERT(a_busy_token, i_clk, i_rst_n, r_busy == (|here || r_fin.valid))
    `MTHW_NEVER(a_count_range, i_clk, i_rst_n, r_count > FULL)
    `MTHW_ASSERT(a_reg_grows, i_clk, i_rst_n,
        (direct_go && (i_opcode == OP_REGISTER) && reg_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))

endmodule

>>> tb/sv/tb_multi_task_heartbeat_watchdog.sv
// Self-checking testbench for the multi-task heartbeat watchdog.
// Depends on mthw_pkg and multi_task_heartbeat_watchdog; predicts each result
// from its own copy of the task table and compares every field as it leaves.
`timescale 1ns / 1ps

module tb_multi_task_heartbeat_watchdog;
    import mthw_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int RANDOM_ITEMS = 60;
    localparam int TAIL_ITEMS = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_opcode = OP_CLEAR;
    logic [ID_W-1:0]       i_task_id = '0;
    logic [TIME_W-1:0]     i_period_ns = '0;
    logic [TIME_W-1:0]     i_now_ns = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [KIND_W-1:0]     o_kind;
    logic                  o_accepted;
    logic [OUT_SLOT_W-1:0] o_slot_index;
    logic [ID_W-1:0]       o_missed_task;
    logic [MISS_W-1:0]     o_miss_total;
    logic [HEALTH_W-1:0]   o_health;
    logic                  o_last;

    // Shadow copy of the watched-task table.
    int                tbl_count;
    logic [ID_W-1:0]   tbl_task [SLOTS];
    logic [TIME_W-1:0] tbl_period [SLOTS];
    logic [TIME_W-1:0] tbl_seen [SLOTS];
    logic [MISS_W-1:0] tbl_misses [SLOTS];

    t_res pending_results[$];
    t_res head_result;
    int   failure_count = 0;
    int   requests_sent = 0;
    int   stall_left = 0;
    bit   no_idle = 1'b0;

    multi_task_heartbeat_watchdog u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_task_id     (i_task_id),
        .i_period_ns   (i_period_ns),
        .i_now_ns      (i_now_ns),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_accepted    (o_accepted),
        .o_slot_index  (o_slot_index),
        .o_missed_task (o_missed_task),
        .o_miss_total  (o_miss_total),
        .o_health      (o_health),
        .o_last        (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Works out the results of one accepted request and updates the table.
    task automatic predict_watchdog(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] period,
                                    input logic [TIME_W-1:0] now);
        t_res              r;
        logic [TIME_W-1:0] elapsed;
        logic [HEALTH_W-1:0] worst;
        bit                hit;
        r = '0;
        r.kind = KIND_ACK;
        r.last = 1'b1;
        hit = 1'b0;
        worst = HEALTH_OK;
        case (op)
            OP_CLEAR: begin
                tbl_count = 0;
                r.accepted = 1'b1;
                pending_results.push_back(r);
            end
            OP_REGISTER: begin
                if (tbl_count < SLOTS) begin
                    tbl_task[tbl_count] = id;
                    tbl_period[tbl_count] = period;
                    tbl_seen[tbl_count] = now;
                    tbl_misses[tbl_count] = '0;
                    r.accepted = 1'b1;
                    r.slot = tbl_count[OUT_SLOT_W-1:0];
                    tbl_count++;
                end
                pending_results.push_back(r);
            end
            OP_HEARTBEAT: begin
                // Only the first entry with a matching id is refreshed.
                for (int i = 0; i < tbl_count && !hit; i++) begin
                    if (tbl_task[i] == id) begin
                        tbl_seen[i] = now;
                        r.accepted = 1'b1;
                        r.slot = i[OUT_SLOT_W-1:0];
                        hit = 1'b1;
                    end
                end
                pending_results.push_back(r);
            end
            default: begin
                // Deadline walk; elapsed time wraps, and a period with its top
                // bit set can never be doubled past, so it never expires.
                for (int i = 0; i < tbl_count; i++) begin
                    elapsed = now - tbl_seen[i];
                    if (!tbl_period[i][TIME_W-1] &&
                        elapsed > {tbl_period[i][TIME_W-2:0], 1'b0}) begin
                        tbl_misses[i] = tbl_misses[i] + 1'b1;
                        r = '0;
                        r.kind = KIND_MISS;
                        r.slot = i[OUT_SLOT_W-1:0];
                        r.missed_task = tbl_task[i];
                        r.miss_total = tbl_misses[i];
                        pending_results.push_back(r);
                        worst = HEALTH_EXPIRED;
                    end else if (elapsed > tbl_period[i] && worst < HEALTH_LATE) begin
                        worst = HEALTH_LATE;
                    end
                end
                r = '0;
                r.kind = KIND_SUMMARY;
                r.health = worst;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
        endcase
    endtask

    // Presents one request, waits for it to be taken and records its results.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] period,
                                input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_task_id <= id;
        i_period_ns <= period;
        i_now_ns <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_watchdog(op, id, period, now);
        requests_sent++;
    endtask

    // Drops the request line and waits until every predicted result is out.
    task automatic hold_until_results_done();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            failure_count++;
        end
    endfunction

    // Result checker: every accepted result is matched with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d with nothing predicted", o_kind);
                failure_count++;
            end else begin
                head_result = pending_results.pop_front();
                check_field("kind", 32'(head_result.kind), 32'(o_kind));
                check_field("accepted", 32'(head_result.accepted), 32'(o_accepted));
                check_field("slot_index", 32'(head_result.slot), 32'(o_slot_index));
                check_field("missed_task", head_result.missed_task, o_missed_task);
                check_field("miss_total", head_result.miss_total, o_miss_total);
                check_field("health", 32'(head_result.health), 32'(o_health));
                check_field("last", 32'(head_result.last), 32'(o_last));
            end
        end
    end

    // Output stall in random bursts, switched off for the closing stretch.
    always @(negedge i_clk) begin
        if (no_idle) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Commands on an empty table.
    task automatic test_empty_table();
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_HEARTBEAT, 32'h0000_0005, '0, 64'd10);
        send_request(OP_CHECK, '0, '0, '1);
    endtask

    // Fills every slot with extreme and duplicate entries, then overflows.
    task automatic test_register_fill();
        send_request(OP_CLEAR, '1, '1, '1);
        send_request(OP_REGISTER, '0, '0, '0);
        send_request(OP_REGISTER, '1, '1, '1);
        send_request(OP_REGISTER, 32'd5, 64'h8000_0000_0000_0000, '0);
        send_request(OP_REGISTER, 32'd5, 64'd100, 64'd1000);
        send_request(OP_REGISTER, 32'd7, 64'd10, 64'd50);
        send_request(OP_REGISTER, 32'd9, 64'd100, '0);
        send_request(OP_REGISTER, 32'd10, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_request(OP_REGISTER, 32'd11, 64'd1, '0);
        send_request(OP_REGISTER, 32'd12, 64'd1, '0);
    endtask

    // Heartbeat lookup with duplicates and unknown ids, then checks where
    // the time runs backwards past zero.
    task automatic test_heartbeat_lookup();
        send_request(OP_HEARTBEAT, 32'd5, '0, 64'd2000);
        send_request(OP_HEARTBEAT, 32'hDEAD_BEEF, '0, 64'd2000);
        send_request(OP_HEARTBEAT, '1, '1, '0);
        send_request(OP_CHECK, '0, '0, '0);
        send_request(OP_CHECK, '1, '1, '1);
    endtask

    // Elapsed time exactly at and just past one and two periods.
    task automatic test_deadline_edges();
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_REGISTER, 32'h0000_0100, 64'd100, 64'd1000);
        send_request(OP_CHECK, '0, '0, 64'd1100);
        send_request(OP_CHECK, '0, '0, 64'd1101);
        send_request(OP_CHECK, '0, '0, 64'd1200);
        send_request(OP_CHECK, '0, '0, 64'd1201);
    endtask

    // Random sessions: clear, register a set of tasks, then heartbeats and
    // checks on an advancing clock, with some full-width noise mixed in.
    task automatic test_random_traffic(input int item_goal);
        logic [TIME_W-1:0] clock_ns;
        logic [TIME_W-1:0] period;
        logic [ID_W-1:0]   id_pool [6];
        int                start_count;
        int                pick;
        bit                paused;
        clock_ns = {$urandom, $urandom};
        start_count = requests_sent;
        paused = 1'b0;
        while (requests_sent - start_count < item_goal) begin
            foreach (id_pool[k]) id_pool[k] = $urandom;
            id_pool[0] = $urandom_range(1) ? '1 : '0;
            send_request(OP_CLEAR, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
            repeat ($urandom_range(1, SLOTS + 2)) begin
                period = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(1, 600));
                send_request(OP_REGISTER, id_pool[$urandom_range(5)], period, clock_ns);
                clock_ns += 64'($urandom_range(50));
            end
            repeat ($urandom_range(4, 12)) begin
                pick = $urandom_range(99);
                if ($urandom_range(19) == 0)
                    clock_ns -= 64'($urandom_range(1, 2000));
                else
                    clock_ns += 64'($urandom_range(700));
                if (pick < 45)
                    send_request(OP_HEARTBEAT, id_pool[$urandom_range(5)],
                                 {$urandom, $urandom}, clock_ns);
                else if (pick < 85)
                    send_request(OP_CHECK, $urandom, {$urandom, $urandom}, clock_ns);
                else
                    send_request(OP_W'($urandom_range(OP_CHECK)), $urandom,
                                 {$urandom, $urandom}, {$urandom, $urandom});
            end
            // Let the block run completely dry once per call, outside the closing stretch.
            if (!paused && !no_idle) begin
                hold_until_results_done();
                paused = 1'b1;
            end
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(TAIL_ITEMS);
    endtask

    initial begin
        tbl_count = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_register_fill();
        test_heartbeat_lookup();
        test_deadline_edges();
        test_random_traffic(RANDOM_ITEMS);
        test_back_to_back();
        hold_until_results_done();
        repeat (3 * SLOTS + 10) @(posedge i_clk);
        if (failure_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog on the run itself.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> multi_task_heartbeat_watchdog.f
+incdir+rtl/core
rtl/core/mthw_pkg.sv
rtl/core/mthw_cell.sv
rtl/core/multi_task_heartbeat_watchdog.sv
tb/sv/tb_multi_task_heartbeat_watchdog.sv
